### rtl/hds_pkg.sv
// ============================================================================
// hds_pkg
// Shared types and constants for the 1-D heat diffusion step engine.
// ============================================================================
package hds_pkg;

    // Row geometry
    localparam int MAX_CELLS = 256;
    localparam int ADDR_W    = $clog2(MAX_CELLS);
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);

    // Field and register widths
    localparam int TEMP_W    = 25;
    localparam int RATIO_W   = 16;
    localparam int TSTEP_W   = 32;
    localparam int TIME_W    = 48;
    localparam int STEPS_W   = 32;
    localparam int CC_W      = 9;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int REQ_W     = 2;
    localparam int CIDX_W    = 8;

    // Width used when clamping the cell count
    localparam int EW = (CNT_W > CC_W) ? CNT_W : CC_W;

    // Arithmetic widths: laplacian, product, rounded delta, candidate value
    localparam int FRAC_W  = 16;
    localparam int LAP_W   = TEMP_W + 3;
    localparam int PROD_W  = LAP_W + RATIO_W + 1;
    localparam int DELTA_W = PROD_W - FRAC_W;
    localparam int VAL_W   = DELTA_W + 1;

    localparam logic [PROD_W-1:0] ROUND_BIAS     = PROD_W'(1 << (FRAC_W - 1));
    localparam logic [TEMP_W-1:0] TEMP_MAX       = '1;
    localparam logic [TEMP_W-1:0] INTERIOR_START = TEMP_W'(19660800);

    // Reset values of the configuration registers
    localparam logic [RATIO_W-1:0] RATIO_RESET = '0;
    localparam logic [TSTEP_W-1:0] TSTEP_RESET = TSTEP_W'(65536);
    localparam logic [TIME_W-1:0]  END_RESET   = TIME_W'(6553600);
    localparam logic [STEPS_W-1:0] MAXS_RESET  = STEPS_W'(1000);
    localparam int                 CC_RESET    = 256;
    localparam logic [CC_W-1:0]    CC_RESET_V  = CC_W'(CC_RESET);
    localparam int RESET_NCELLS = (CC_RESET > MAX_CELLS) ? MAX_CELLS : CC_RESET;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TSTEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TIME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS    = 3'd4;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_STEP    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CIDX_W-1:0] cell_index;
    } t_req;

    typedef struct packed {
        logic               stepped;
        logic               done_res;
        logic [STEPS_W-1:0] steps_taken;
        logic [TEMP_W-1:0]  cell_temp;
    } t_res;

    // Read beat from the cell store into the update unit
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] idx;
        logic [TEMP_W-1:0] temp;
    } t_rd_beat;

    // Write request into the cell store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [TEMP_W-1:0] data;
    } t_wr_req;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SWEEP,
        S_DRAIN,
        S_FINISH
    } t_state;

endpackage

### rtl/hds_req_if.sv
// ============================================================================
// hds_req_if
// Request channel: valid/ready handshake carrying one request beat.
// ============================================================================
interface hds_req_if import hds_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/hds_res_if.sv
// ============================================================================
// hds_res_if
// Result channel: valid/ready handshake carrying one result beat.
// ============================================================================
interface hds_res_if import hds_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/hds_temp_mem.sv
// ============================================================================
// hds_temp_mem
// Cell temperature store: one write port, one registered read port.
// ============================================================================
module hds_temp_mem import hds_pkg::*; (
    input  logic              i_clk,
    input  t_wr_req           i_wr,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [TEMP_W-1:0] o_rd_data
);

    logic [TEMP_W-1:0] r_mem [MAX_CELLS];
    logic [TEMP_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/hds_cell_unit.sv
// ============================================================================
// hds_cell_unit
// Shared cell update unit: three-point window, laplacian, multiply by the
// ratio, round half up and clamp. One cell per beat, through stages A and B.
// ============================================================================
module hds_cell_unit import hds_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [RATIO_W-1:0] i_ratio,
    input  t_rd_beat           i_rd,
    output t_wr_req            o_wr,
    output logic               o_busy
);

    // window: two previous cells, incoming beat is the right neighbor
    logic [TEMP_W-1:0] r_left;
    logic [TEMP_W-1:0] r_mid;

    // stage A: laplacian
    logic                    r_a_vld;
    logic signed [LAP_W-1:0] r_a_lap;
    logic [TEMP_W-1:0]       r_a_mid;
    logic [ADDR_W-1:0]       r_a_addr;

    // stage B: product
    logic                     r_b_vld;
    logic signed [PROD_W-1:0] r_b_prod;
    logic [TEMP_W-1:0]        r_b_mid;
    logic [ADDR_W-1:0]        r_b_addr;

    logic signed [LAP_W-1:0]   w_lap;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_sum;
    logic signed [DELTA_W-1:0] w_delta;
    logic signed [VAL_W-1:0]   w_val;
    logic [TEMP_W-1:0]         w_new;
    logic                      w_a_go;

    assign w_lap = $signed({3'b000, r_left}) - $signed({2'b00, r_mid, 1'b0})
                 + $signed({3'b000, i_rd.temp});
    assign w_a_go = i_rd.vld && (i_rd.idx >= ADDR_W'(2));
    assign w_prod = r_a_lap * $signed({1'b0, i_ratio});

    always_ff @(posedge i_clk) begin
        if (i_rd.vld) begin
            r_left <= r_mid;
            r_mid  <= i_rd.temp;
        end
        r_a_lap  <= w_lap;
        r_a_mid  <= r_mid;
        r_a_addr <= i_rd.idx - ADDR_W'(1);
        r_b_prod <= w_prod;
        r_b_mid  <= r_a_mid;
        r_b_addr <= r_a_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= w_a_go;
            r_b_vld <= r_a_vld;
        end
    end

    // round half up, then saturate into the temperature range
    always_comb begin
        w_sum   = r_b_prod + $signed(ROUND_BIAS);
        w_delta = w_sum[PROD_W-1:FRAC_W];
        w_val   = $signed({{(VAL_W-TEMP_W){1'b0}}, r_b_mid}) + VAL_W'(w_delta);
        if (w_val[VAL_W-1]) begin
            w_new = '0;
        end else if (|w_val[VAL_W-2:TEMP_W]) begin
            w_new = TEMP_MAX;
        end else begin
            w_new = w_val[TEMP_W-1:0];
        end
    end

    always_comb begin
        o_wr.we   = r_b_vld;
        o_wr.addr = r_b_addr;
        o_wr.data = w_new;
    end

    assign o_busy = r_a_vld | r_b_vld;

endmodule

### rtl/heat_diffusion_1d_step_core.sv
// ============================================================================
// heat_diffusion_1d_step_core
// Explicit Euler (FTCS) 1-D heat diffusion engine over a row of Q9.16 cells.
// ============================================================================
// Usage:
//   Requests arrive as beats on i_req (valid/ready); each one answers with
//   exactly one result beat on o_res. Codes: step, read cell, restart, and a
//   spare code that only reports status.
//   Configuration is a plain write port (i_cfg_we / i_cfg_idx / i_cfg_data),
//   to be written only while no request is in flight.
//   Work done per request, with n the effective cell count:
//     step     one cell store read per cycle through the shared update
//              unit for each of the n cells, then its pipeline drains
//     step refused (limit reached), no-op code: status only
//     read     one registered read of the cell store
//     restart  every cell is rewritten, one per cycle
//   One request is worked at a time; ready is high only while idle. The
//   result sits in an output register, so a new request is taken while the
//   last result still waits; a stalled receiver only holds up the end of the
//   following request.
//   Reset (synchronous, active low) loads the register defaults and then
//   sweeps the initial profile into every cell of the store; no request is
//   taken until the sweep is done.
// ============================================================================
module heat_diffusion_1d_step_core import hds_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    hds_req_if.sink              i_req,
    hds_res_if.source            o_res
);

    // configuration
    logic [RATIO_W-1:0] r_ratio;
    logic [TSTEP_W-1:0] r_tstep;
    logic [TIME_W-1:0]  r_end_time;
    logic [STEPS_W-1:0] r_max_steps;
    logic [CC_W-1:0]    r_cell_count;

    // sequencer and status
    t_state             r_state,   n_state;
    logic [CNT_W-1:0]   r_cnt,     n_cnt;
    t_req               r_req,     n_req;
    logic               r_stepped, n_stepped;
    logic [TEMP_W-1:0]  r_temp,    n_temp;
    logic               r_reply,   n_reply;
    logic [STEPS_W-1:0] r_steps,   n_steps;
    logic [TIME_W-1:0]  r_elapsed, n_elapsed;
    t_res               r_out,     n_out;
    logic               r_out_vld, n_out_vld;
    logic               r_rd_vld,  n_rd_vld;
    logic [ADDR_W-1:0]  r_rd_idx,  n_rd_idx;

    logic [EW-1:0]      w_cc_ext;
    logic [CNT_W-1:0]   w_ncells;
    logic [CNT_W-1:0]   w_fill_n;
    logic               w_done;
    logic               w_idx_ok;
    logic [TIME_W:0]    w_time_sum;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [TEMP_W-1:0]  w_rd_data;
    t_wr_req            w_wr;
    t_wr_req            w_cu_wr;
    t_rd_beat           w_rd;
    logic               w_cu_busy;

    // effective cell count: clamp to 2 .. MAX_CELLS
    always_comb begin
        w_cc_ext = EW'(r_cell_count);
        if (w_cc_ext < EW'(2)) begin
            w_ncells = CNT_W'(2);
        end else if (w_cc_ext > EW'(MAX_CELLS)) begin
            w_ncells = CNT_W'(MAX_CELLS);
        end else begin
            w_ncells = CNT_W'(w_cc_ext);
        end
    end

    // reset fill uses the reset cell count, restart the current one
    assign w_fill_n = r_reply ? w_ncells : CNT_W'(RESET_NCELLS);

    assign w_done   = (r_steps >= r_max_steps) || (r_elapsed >= r_end_time);
    assign w_idx_ok = EW'(r_req.cell_index) < EW'(w_ncells);
    assign w_time_sum = {1'b0, r_elapsed} + (TIME_W + 1)'(r_tstep);

    assign w_rd.vld  = r_rd_vld;
    assign w_rd.idx  = r_rd_idx;
    assign w_rd.temp = w_rd_data;

    hds_temp_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    hds_cell_unit u_cu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ratio (r_ratio),
        .i_rd    (w_rd),
        .o_wr    (w_cu_wr),
        .o_busy  (w_cu_busy)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    // sequencer: next state, store port muxing, status updates
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_req     = r_req;
        n_stepped = r_stepped;
        n_temp    = r_temp;
        n_reply   = r_reply;
        n_steps   = r_steps;
        n_elapsed = r_elapsed;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        n_rd_vld  = 1'b0;
        n_rd_idx  = r_rd_idx;
        w_rd_addr = ADDR_W'(r_req.cell_index);
        w_wr      = w_cu_wr;

        if (o_res.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_FILL: begin
                // ends and unused cells zero, interior at 300 K
                w_wr.we   = 1'b1;
                w_wr.addr = r_cnt[ADDR_W-1:0];
                if ((r_cnt != '0) && (({1'b0, r_cnt} + 1'b1) < {1'b0, w_fill_n})) begin
                    w_wr.data = INTERIOR_START;
                end else begin
                    w_wr.data = '0;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MAX_CELLS - 1)) begin
                    n_steps   = '0;
                    n_elapsed = '0;
                    n_state   = r_reply ? S_FINISH : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req   = i_req.data;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_stepped = 1'b0;
                n_temp    = '0;
                n_cnt     = '0;
                unique case (r_req.req_type)
                    REQ_STEP:    n_state = w_done ? S_FINISH : S_SWEEP;
                    REQ_READ:    n_state = S_RDWAIT;
                    REQ_RESTART: begin
                        n_reply = 1'b1;
                        n_state = S_FILL;
                    end
                    default:     n_state = S_FINISH;
                endcase
            end
            S_RDWAIT: begin
                if (w_idx_ok) begin
                    n_temp = w_rd_data;
                end
                n_state = S_FINISH;
            end
            S_SWEEP: begin
                // stream cells 0 .. n-1 into the update unit
                w_rd_addr = r_cnt[ADDR_W-1:0];
                n_rd_vld  = 1'b1;
                n_rd_idx  = r_cnt[ADDR_W-1:0];
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == w_ncells - 1'b1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !w_cu_busy) begin
                    n_elapsed = w_time_sum[TIME_W] ? '1 : w_time_sum[TIME_W-1:0];
                    if (r_steps != '1) begin
                        n_steps = r_steps + 1'b1;
                    end
                    n_stepped = 1'b1;
                    n_state   = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_vld || o_res.ready) begin
                    n_out.stepped     = r_stepped;
                    n_out.done_res    = w_done;
                    n_out.steps_taken = r_steps;
                    n_out.cell_temp   = r_temp;
                    n_out_vld         = 1'b1;
                    n_reply           = 1'b0;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FILL;
            r_cnt     <= '0;
            r_reply   <= 1'b0;
            r_steps   <= '0;
            r_elapsed <= '0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_reply   <= n_reply;
            r_steps   <= n_steps;
            r_elapsed <= n_elapsed;
            r_out_vld <= n_out_vld;
            r_rd_vld  <= n_rd_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_stepped <= n_stepped;
        r_temp    <= n_temp;
        r_out     <= n_out;
        r_rd_idx  <= n_rd_idx;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio      <= RATIO_RESET;
            r_tstep      <= TSTEP_RESET;
            r_end_time   <= END_RESET;
            r_max_steps  <= MAXS_RESET;
            r_cell_count <= CC_RESET_V;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RATIO:    r_ratio      <= i_cfg_data[RATIO_W-1:0];
                CFG_TSTEP:    r_tstep      <= i_cfg_data[TSTEP_W-1:0];
                CFG_END_TIME: r_end_time   <= i_cfg_data[TIME_W-1:0];
                CFG_MAX_STEP: r_max_steps  <= i_cfg_data[STEPS_W-1:0];
                CFG_CELLS:    r_cell_count <= i_cfg_data[CC_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

### sim/tb_heat_diffusion_1d_step_core.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_heat_diffusion_1d_step_core
// Self-checking bench for the 1-D heat diffusion step engine. A directed
// table hits reset values, refused steps, cell-count clamping, reads out of
// range and unstable ratios. Random phases with random register settings
// follow, with idle gaps on the request and result sides. Every result beat
// is checked against a value typed into the table or against a cycle-free
// model of the row that is kept inside the bench.
// ============================================================================
module tb_heat_diffusion_1d_step_core;
    import hds_pkg::*;

    // Spare request code: reports status, changes nothing
    localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 102;
    // Longest silent stretch of a correct run is a full-row step or restart
    // plus a long gap on either side; take it ~10x over
    localparam int STALL_LIMIT = 4000;
    localparam int SHOW_LIMIT  = 10;

    typedef struct packed {
        logic pinned;   // result was typed into the table, not predicted
        t_res res;
    } t_pin;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        t_req                 beat;
        t_pin                 pin;
    } t_row;

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // Channel drive comes from plain bench variables so every input is known
    // from time zero and each interface signal has a single driver
    logic send_vld   = 1'b0;
    t_req send_beat  = '0;
    logic take_ready = 1'b0;

    hds_req_if req_if ();
    hds_res_if res_if ();

    assign req_if.valid = send_vld;
    assign req_if.data  = send_beat;
    assign res_if.ready = take_ready;

    always #1 i_clk = ~i_clk;

    heat_diffusion_1d_step_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    // ------------------------------------------------------------------------
    // Row model: registers, cell row, step counter, elapsed time
    // ------------------------------------------------------------------------
    logic [RATIO_W-1:0] ratio_m;
    logic [TSTEP_W-1:0] tstep_m;
    logic [TIME_W-1:0]  end_m;
    logic [STEPS_W-1:0] max_m;
    logic [CC_W-1:0]    cells_m;

    logic [TEMP_W-1:0]  row_temp [MAX_CELLS];
    logic [STEPS_W-1:0] steps_done_m;
    logic [TIME_W-1:0]  elapsed_m;

    t_res want_q [$];   // results owed by the DUT, oldest first
    t_pin pin_q  [$];   // per request sent: typed result or "use the model"
    t_row plan_q [$];   // directed stimulus table

    bit calm = 1'b0;    // both sides run without idling while set
    int bad_cnt, beats_checked, reg_writes;
    int steps_run, steps_refused, reads_seen, restarts_seen, clamped_cells;

    // cell_count below 2 acts as 2, above the row size as the row size
    function automatic int eff_cells(logic [CC_W-1:0] c);
        int n;
        n = int'(c);
        if (n < 2) n = 2;
        if (n > MAX_CELLS) n = MAX_CELLS;
        return n;
    endfunction

    function automatic logic limit_hit();
        return (steps_done_m >= max_m) || (elapsed_m >= end_m);
    endfunction

    // Ends cold, interior at 300 K, everything past the live row cold
    function automatic void load_row();
        int n;
        n = eff_cells(cells_m);
        for (int i = 0; i < MAX_CELLS; i++)
            row_temp[i] = (i >= 1 && i + 1 < n) ? INTERIOR_START : '0;
        steps_done_m = '0;
        elapsed_m    = '0;
    endfunction

    // One FTCS update from the old row; product rounded half up to the Q9.16
    // scale of the cells, new value clamped to the 25-bit range
    function automatic void diffuse_row();
        logic [TEMP_W-1:0] fresh [MAX_CELLS];
        logic [TIME_W:0]   t_sum;
        longint lap, prod, dlt, v;
        int n;
        n = eff_cells(cells_m);
        for (int i = 1; i + 1 < n; i++) begin
            lap  = longint'(row_temp[i-1]) - 2 * longint'(row_temp[i])
                 + longint'(row_temp[i+1]);
            prod = lap * longint'(ratio_m);
            dlt  = (prod + 64'sd32768) >>> 16;
            v    = longint'(row_temp[i]) + dlt;
            if (v < 0) begin
                v = 0;
                clamped_cells++;
            end else if (v > longint'(TEMP_MAX)) begin
                v = longint'(TEMP_MAX);
                clamped_cells++;
            end
            fresh[i] = TEMP_W'(v);
        end
        for (int i = 1; i + 1 < n; i++)
            row_temp[i] = fresh[i];
        t_sum = {1'b0, elapsed_m} + (TIME_W+1)'(tstep_m);
        elapsed_m = t_sum[TIME_W] ? '1 : t_sum[TIME_W-1:0];
        if (steps_done_m != '1) steps_done_m++;
    endfunction

    function automatic t_res answer_req(t_req rq);
        t_res r;
        r = '0;
        case (rq.req_type)
            REQ_STEP: begin
                if (!limit_hit()) begin
                    diffuse_row();
                    r.stepped = 1'b1;
                    steps_run++;
                end else begin
                    steps_refused++;
                end
            end
            REQ_READ: begin
                reads_seen++;
                if (int'(rq.cell_index) < eff_cells(cells_m))
                    r.cell_temp = row_temp[rq.cell_index];
            end
            REQ_RESTART: begin
                restarts_seen++;
                load_row();
            end
            default: ;
        endcase
        r.done_res    = limit_hit();
        r.steps_taken = steps_done_m;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: mirrors register writes, checks result beats, predicts on
    // every accepted request. One block, so ordering within an edge is fixed.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        t_pin pin;
        if (!i_rst_n) begin
            ratio_m = RATIO_RESET;
            tstep_m = TSTEP_RESET;
            end_m   = END_RESET;
            max_m   = MAXS_RESET;
            cells_m = CC_RESET_V;
            load_row();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RATIO:    ratio_m = i_cfg_data[RATIO_W-1:0];
                    CFG_TSTEP:    tstep_m = i_cfg_data[TSTEP_W-1:0];
                    CFG_END_TIME: end_m   = i_cfg_data[TIME_W-1:0];
                    CFG_MAX_STEP: max_m   = i_cfg_data[STEPS_W-1:0];
                    CFG_CELLS:    cells_m = i_cfg_data[CC_W-1:0];
                    default: ;
                endcase
            end
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                beats_checked++;
                if (want_q.size() == 0) begin
                    bad_cnt++;
                    if (bad_cnt <= SHOW_LIMIT)
                        $display("%0t: result beat with nothing owed: st %0b dn %0b n %0d t %0d",
                                 $time, got.stepped, got.done_res, got.steps_taken,
                                 got.cell_temp);
                end else begin
                    want = want_q.pop_front();
                    if (got.stepped !== want.stepped || got.done_res !== want.done_res ||
                        got.steps_taken !== want.steps_taken ||
                        got.cell_temp !== want.cell_temp) begin
                        bad_cnt++;
                        if (bad_cnt <= SHOW_LIMIT)
                            $display({"%0t: mismatch exp/act stepped %0b/%0b done %0b/%0b ",
                                      "steps %0d/%0d temp %0d/%0d"}, $time,
                                     want.stepped, got.stepped, want.done_res, got.done_res,
                                     want.steps_taken, got.steps_taken,
                                     want.cell_temp, got.cell_temp);
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                pin = pin_q.pop_front();
                got = answer_req(req_if.data);
                want_q.push_back(pin.pinned ? pin.res : got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run after too many cycles with no beat on either side
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results still owed",
                     $time, quiet_cycles, want_q.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Idling: mostly short gaps, now and then a long one
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Result side back-pressure
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            take_ready <= 1'b0;
            hold_left  <= 0;
        end else if (calm) begin
            take_ready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            take_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 25) begin
            hold_left  <= pick_gap();
            take_ready <= 1'b0;
        end else begin
            take_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Hold valid with the beat until it is taken; valid stays high on exit so
    // back-to-back beats never drop it. Callers that pause go through settle.
    task automatic send_req(t_req beat, t_pin pin);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 40) ? pick_gap() : 0;
        if (gap > 0) begin
            send_vld <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pin_q.push_back(pin);
        send_vld  <= 1'b1;
        send_beat <= beat;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic settle();
        send_vld <= 1'b0;
        @(posedge i_clk);
        while (want_q.size() != 0 || pin_q.size() != 0) @(posedge i_clk);
    endtask

    // Register write, only ever with the engine idle
    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------------
    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        t_row r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        plan_q.push_back(r);
    endfunction

    function automatic void add_req(logic [REQ_W-1:0] kind, logic [CIDX_W-1:0] idx);
        t_row r;
        r = '0;
        r.beat.req_type   = kind;
        r.beat.cell_index = idx;
        plan_q.push_back(r);
    endfunction

    function automatic void add_pin(logic [REQ_W-1:0] kind, logic [CIDX_W-1:0] idx,
                                    logic st, logic dn, logic [STEPS_W-1:0] cnt,
                                    logic [TEMP_W-1:0] tmp);
        t_row r;
        r = '0;
        r.beat.req_type      = kind;
        r.beat.cell_index    = idx;
        r.pin.pinned         = 1'b1;
        r.pin.res.stepped    = st;
        r.pin.res.done_res   = dn;
        r.pin.res.steps_taken = cnt;
        r.pin.res.cell_temp  = tmp;
        plan_q.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // One random phase: fresh register set, restart, then a random mix that
    // is mostly steps and reads, with restarts reviving a finished run
    // ------------------------------------------------------------------------
    task automatic run_phase(int ph);
        logic [CC_W-1:0]    cc_val;
        logic [RATIO_W-1:0] ratio;
        logic [TSTEP_W-1:0] tstep;
        logic [TIME_W-1:0]  stop_at;
        logic [STEPS_W-1:0] step_cap;
        logic [REQ_W-1:0]   kind;
        logic [CIDX_W-1:0]  idx;
        int n_eff, roll;

        calm = (ph % 4 == 3);

        // Mostly short rows; one full row, one clamped high, one clamped low
        if (ph == 2)      cc_val = CC_W'(MAX_CELLS);
        else if (ph == 5) cc_val = CC_W'($urandom_range(MAX_CELLS + 1, 511));
        else if (ph == 8) cc_val = CC_W'($urandom_range(0, 1));
        else if ($urandom_range(0, 9) < 3) cc_val = CC_W'($urandom_range(25, 64));
        else cc_val = CC_W'($urandom_range(2, 24));
        n_eff = eff_cells(cc_val);

        // Stable limit every fourth phase, an unstable one in phase 6
        if (ph % 4 == 0)                  ratio = 16'd32768;
        else if (ph == 6)                 ratio = 16'hFFFF;
        else if ($urandom_range(0, 4) == 0) ratio = RATIO_W'($urandom_range(0, 65535));
        else                              ratio = RATIO_W'($urandom_range(0, 32768));

        roll = $urandom_range(0, 99);
        if (roll < 25)      tstep = TSTEP_RESET;
        else if (roll < 45) tstep = 32'd1;
        else if (roll < 55) tstep = '1;
        else                tstep = TSTEP_W'($urandom_range(1, 32'hFFFF_FFFF));

        // End time lands exactly on a step boundary, or out of reach
        roll = $urandom_range(0, 99);
        if (ph == 7 && roll < 30) stop_at = '0;
        else if (roll < 20)       stop_at = '1;
        else stop_at = TIME_W'(tstep) * TIME_W'($urandom_range(5, 70));

        roll = $urandom_range(0, 99);
        if (ph == 4)        step_cap = 32'd1;
        else if (roll < 40) step_cap = STEPS_W'($urandom_range(5, 70));
        else if (roll < 80) step_cap = '1;
        else                step_cap = STEPS_W'($urandom_range(1, 4));

        set_reg(CFG_RATIO,    CFG_W'(ratio));
        set_reg(CFG_TSTEP,    CFG_W'(tstep));
        set_reg(CFG_END_TIME, CFG_W'(stop_at));
        set_reg(CFG_MAX_STEP, CFG_W'(step_cap));
        set_reg(CFG_CELLS,    CFG_W'(cc_val));
        send_req('{req_type: REQ_RESTART, cell_index: CIDX_W'($urandom)}, '0);

        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 2) settle();
            // Some phases resize the row mid-run without reloading it
            if (k == PHASE_ITEMS / 2 && ph % 3 == 1) begin
                cc_val = CC_W'($urandom_range(2, 40));
                n_eff  = eff_cells(cc_val);
                set_reg(CFG_CELLS, CFG_W'(cc_val));
            end
            roll = $urandom_range(0, 99);
            if (roll < 55)      kind = REQ_STEP;
            else if (roll < 85) kind = REQ_READ;
            else if (roll < 91) kind = REQ_RESTART;
            else                kind = REQ_NOP;
            if (kind == REQ_READ && $urandom_range(0, 3) != 0)
                idx = CIDX_W'($urandom_range(0, n_eff - 1));
            else
                idx = CIDX_W'($urandom_range(0, 255));
            send_req('{req_type: kind, cell_index: idx}, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: r = 0, 1 s per step, stop at 100 s or 1000 steps,
        // full 256-cell row
        add_pin(REQ_READ,    8'd0,   1'b0, 1'b0, 32'd0, '0);
        add_pin(REQ_READ,    8'd1,   1'b0, 1'b0, 32'd0, INTERIOR_START);
        add_pin(REQ_READ,    8'd255, 1'b0, 1'b0, 32'd0, '0);
        add_pin(REQ_NOP,     8'hFF,  1'b0, 1'b0, 32'd0, '0);
        add_pin(REQ_STEP,    8'd0,   1'b1, 1'b0, 32'd1, '0);    // r = 0, row unchanged
        add_pin(REQ_READ,    8'd128, 1'b0, 1'b0, 32'd1, INTERIOR_START);
        add_pin(REQ_RESTART, 8'h55,  1'b0, 1'b0, 32'd0, '0);

        // Half ratio on five cells, step limit of three
        add_cfg(CFG_RATIO,    CFG_W'(32768));
        add_cfg(CFG_CELLS,    CFG_W'(5));
        add_cfg(CFG_MAX_STEP, CFG_W'(3));
        add_pin(REQ_RESTART, 8'd0, 1'b0, 1'b0, 32'd0, '0);
        add_req(REQ_STEP, 8'd0);
        add_req(REQ_STEP, 8'd0);
        add_req(REQ_STEP, 8'd0);
        add_pin(REQ_STEP, 8'd0, 1'b0, 1'b1, 32'd3, '0);         // limit reached: refused
        add_req(REQ_READ, 8'd2);
        add_pin(REQ_READ, 8'd5, 1'b0, 1'b1, 32'd3, '0);         // past the live row

        // Grow the row in place: new cells stay cold
        add_cfg(CFG_CELLS, CFG_W'(8));
        add_pin(REQ_READ, 8'd6, 1'b0, 1'b1, 32'd3, '0);

        // End time of zero refuses any step
        add_cfg(CFG_MAX_STEP, CFG_W'(100));
        add_cfg(CFG_END_TIME, CFG_W'(0));
        add_pin(REQ_STEP, 8'd0, 1'b0, 1'b1, 32'd3, '0);

        // Cell count below two: two cells, nothing interior
        add_cfg(CFG_CELLS,    CFG_W'(0));
        add_cfg(CFG_END_TIME, {CFG_W{1'b1}});
        add_cfg(CFG_TSTEP,    CFG_W'(1));
        add_pin(REQ_RESTART, 8'd0, 1'b0, 1'b0, 32'd0, '0);
        add_pin(REQ_STEP,    8'd0, 1'b1, 1'b0, 32'd1, '0);
        add_pin(REQ_READ,    8'd1, 1'b0, 1'b0, 32'd1, '0);
        add_pin(REQ_READ,    8'd2, 1'b0, 1'b0, 32'd1, '0);

        // Count above the row size clamps; ratio near one blows up and the
        // cells near the ends clamp at both rails within three steps
        add_cfg(CFG_CELLS, CFG_W'(511));
        add_cfg(CFG_RATIO, CFG_W'(16'hFFFF));
        add_pin(REQ_RESTART, 8'd0, 1'b0, 1'b0, 32'd0, '0);
        add_req(REQ_STEP, 8'd0);
        add_req(REQ_STEP, 8'd0);
        add_req(REQ_STEP, 8'd0);
        add_req(REQ_READ, 8'd1);
        add_req(REQ_READ, 8'd2);

        foreach (plan_q[k]) begin
            if (plan_q[k].is_cfg) set_reg(plan_q[k].reg_idx, plan_q[k].reg_val);
            else send_req(plan_q[k].beat, plan_q[k].pin);
        end

        for (int ph = 0; ph < PHASES; ph++) run_phase(ph);

        // Drain, then give a stray beat time to show up
        calm = 1'b1;
        settle();
        repeat (MAX_CELLS + 16) @(posedge i_clk);

        $display("covered %0d steps, %0d refused, %0d reads, %0d restarts, %0d clamped cells",
                 steps_run, steps_refused, reads_seen, restarts_seen, clamped_cells);
        $display("%0d register writes, %0d result beats checked, %0d mismatches",
                 reg_writes, beats_checked, bad_cnt);
        if (bad_cnt == 0 && want_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
